// ===== rtl/tup_pkg.sv =====
`timescale 1ns / 1ps

package tup_pkg;

  // Position counter width; the counter saturates at its all-ones value
  localparam int OFFSET_BITS = 16;

  localparam int CH_W       = 8;
  localparam int BASE_W     = 6;
  localparam int VALUE_W    = 32;
  localparam int END_OFS_W  = 16;

  localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(10);

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            first;
  } item_t;

  // Input register contents, as seen by the parse stage
  typedef struct packed {
    logic  valid;
    item_t item;
  } item_req_t;

  typedef struct packed {
    logic [VALUE_W-1:0]   value;
    logic                 overflowed;
    logic                 any_digits;
    logic [END_OFS_W-1:0] end_offset;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } result_req_t;

endpackage

// ===== rtl/tup_in_stage.sv =====
`timescale 1ns / 1ps

module tup_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [7:0]        in_ch,
  input  logic              in_first,
  output logic              in_stall,
  input  logic              take_ok,
  output tup_pkg::item_req_t cur
);
  import tup_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r, item_nxt;
  logic  accept;
  logic  consume;

  assign consume  = valid_r && take_ok;
  assign in_stall = valid_r && !take_ok;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (accept) begin
      valid_nxt     = 1'b1;
      item_nxt.ch   = in_ch;
      item_nxt.first = in_first;
    end else if (consume) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign cur.valid = valid_r;
  assign cur.item  = item_r;

endmodule

// ===== rtl/tup_parse.sv =====
`timescale 1ns / 1ps

module tup_parse (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr,
  input  logic [5:0]             cfg_number_base,
  input  tup_pkg::item_req_t     cur,
  input  logic                   out_free,
  output tup_pkg::result_req_t   load
);
  import tup_pkg::*;

  localparam logic [2:0] PH_SPACE  = 3'd0;
  localparam logic [2:0] PH_SIGNED = 3'd1;
  localparam logic [2:0] PH_ZERO   = 3'd2;
  localparam logic [2:0] PH_DIGITS = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;

  localparam logic [CH_W-1:0] CH_0     = 8'h30;
  localparam logic [CH_W-1:0] CH_9     = 8'h39;
  localparam logic [CH_W-1:0] CH_UA    = 8'h41;
  localparam logic [CH_W-1:0] CH_UZ    = 8'h5A;
  localparam logic [CH_W-1:0] CH_LA    = 8'h61;
  localparam logic [CH_W-1:0] CH_LZ    = 8'h7A;
  localparam logic [CH_W-1:0] CH_UA_OF = 8'h37;  // 'A' - 10
  localparam logic [CH_W-1:0] CH_LA_OF = 8'h57;  // 'a' - 10
  localparam logic [CH_W-1:0] CH_LX    = 8'h78;
  localparam logic [CH_W-1:0] CH_UX    = 8'h58;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_SP    = 8'h20;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_CR    = 8'h0D;

  localparam int PROD_W     = VALUE_W + BASE_W;
  localparam int POS_WIDE_W = (OFFSET_BITS > END_OFS_W) ? OFFSET_BITS : END_OFS_W;
  localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

  logic [BASE_W-1:0]      number_base_r;
  logic [2:0]             phase_r, phase_nxt;
  logic [VALUE_W-1:0]     acc_r, acc_nxt;
  logic                   minus_r, minus_nxt;
  logic [BASE_W-1:0]      base_r, base_nxt;
  logic                   any_r, any_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;

  // state after the optional restart at the first character
  logic [2:0]             eff_phase;
  logic [VALUE_W-1:0]     eff_acc;
  logic                   eff_minus;
  logic [BASE_W-1:0]      eff_base;
  logic                   eff_any;
  logic                   eff_ovf;
  logic [OFFSET_BITS-1:0] eff_pos;

  logic [CH_W-1:0]   c;
  logic              fire;
  logic              is_space;
  logic              dig_ok;
  logic [BASE_W-1:0] dig;
  logic              do_feed;
  logic              force_any;
  logic [BASE_W-1:0] feed_base;
  logic              is_digit;
  logic [PROD_W-1:0] prod;
  logic              stop;
  logic [POS_WIDE_W-1:0] pos_wide;

  assign fire = cur.valid && out_free;
  assign c    = cur.item.ch;

  always_comb begin
    if (cur.item.first) begin
      eff_phase = PH_SPACE;
      eff_acc   = '0;
      eff_minus = 1'b0;
      eff_base  = '0;
      eff_any   = 1'b0;
      eff_ovf   = 1'b0;
      eff_pos   = '0;
    end else begin
      eff_phase = phase_r;
      eff_acc   = acc_r;
      eff_minus = minus_r;
      eff_base  = base_r;
      eff_any   = any_r;
      eff_ovf   = ovf_r;
      eff_pos   = pos_r;
    end
  end

  assign is_space = (c == CH_SP) || (c >= CH_TAB && c <= CH_CR);

  always_comb begin
    dig_ok = 1'b1;
    dig    = '0;
    if (c >= CH_0 && c <= CH_9) begin
      dig = BASE_W'(c - CH_0);
    end else if (c >= CH_UA && c <= CH_UZ) begin
      dig = BASE_W'(c - CH_UA_OF);
    end else if (c >= CH_LA && c <= CH_LZ) begin
      dig = BASE_W'(c - CH_LA_OF);
    end else begin
      dig_ok = 1'b0;
    end
  end

  // Phase handling decides the base and whether the character goes to the feed
  always_comb begin
    phase_nxt = eff_phase;
    minus_nxt = eff_minus;
    base_nxt  = eff_base;
    do_feed   = 1'b0;
    force_any = 1'b0;
    unique case (eff_phase) inside
      PH_SPACE, PH_SIGNED: begin
        if (eff_phase == PH_SPACE && is_space) begin
          phase_nxt = PH_SPACE;
        end else if (eff_phase == PH_SPACE && c == CH_MINUS) begin
          minus_nxt = 1'b1;
          phase_nxt = PH_SIGNED;
        end else if (eff_phase == PH_SPACE && c == CH_PLUS) begin
          phase_nxt = PH_SIGNED;
        end else if ((number_base_r == '0 || number_base_r == BASE_W'(16)) && c == CH_0) begin
          base_nxt  = number_base_r;
          phase_nxt = PH_ZERO;
        end else begin
          base_nxt  = (number_base_r == '0) ? BASE_W'(10) : number_base_r;
          phase_nxt = PH_DIGITS;
          do_feed   = 1'b1;
        end
      end
      PH_ZERO: begin
        phase_nxt = PH_DIGITS;
        if (c == CH_LX || c == CH_UX) begin
          base_nxt = BASE_W'(16);
        end else begin
          // the leading zero counts as a digit; accumulator is still zero
          base_nxt  = (eff_base == '0) ? BASE_W'(8) : BASE_W'(16);
          force_any = 1'b1;
          do_feed   = 1'b1;
        end
      end
      PH_DIGITS: begin
        do_feed = 1'b1;
      end
      default: begin
        phase_nxt = eff_phase;
      end
    endcase
  end

  assign feed_base = base_nxt;
  assign is_digit  = dig_ok && (dig < feed_base);
  assign prod      = PROD_W'(eff_acc) * PROD_W'(feed_base) + PROD_W'(dig);
  assign stop      = do_feed && !is_digit;

  always_comb begin
    acc_nxt = eff_acc;
    any_nxt = eff_any || force_any;
    ovf_nxt = eff_ovf;
    if (do_feed && is_digit) begin
      any_nxt = 1'b1;
      if (eff_ovf || prod[PROD_W-1:VALUE_W] != '0) begin
        ovf_nxt = 1'b1;
      end else begin
        acc_nxt = prod[VALUE_W-1:0];
      end
    end
  end

  assign pos_nxt  = (eff_pos != POS_MAX) ? eff_pos + 1'b1 : eff_pos;
  assign pos_wide = POS_WIDE_W'(eff_pos);

  always_comb begin
    load.valid = fire && stop;
    if (ovf_nxt) begin
      load.res.value = '1;
    end else if (eff_minus) begin
      load.res.value = '0 - acc_nxt;
    end else begin
      load.res.value = acc_nxt;
    end
    load.res.overflowed = ovf_nxt;
    load.res.any_digits = any_nxt;
    load.res.end_offset = any_nxt ? pos_wide[END_OFS_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      number_base_r <= BASE_RESET;
    end else if (cfg_wr) begin
      number_base_r <= cfg_number_base;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SPACE;
      acc_r   <= '0;
      minus_r <= 1'b0;
      base_r  <= '0;
      any_r   <= 1'b0;
      ovf_r   <= 1'b0;
      pos_r   <= '0;
    end else if (fire) begin
      phase_r <= stop ? PH_DONE : phase_nxt;
      acc_r   <= acc_nxt;
      minus_r <= minus_nxt;
      base_r  <= base_nxt;
      any_r   <= any_nxt;
      ovf_r   <= ovf_nxt;
      pos_r   <= pos_nxt;
    end
  end

endmodule

// ===== rtl/tup_out_stage.sv =====
`timescale 1ns / 1ps

module tup_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tup_pkg::result_req_t load,
  output logic                 out_free,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [31:0]          out_value,
  output logic                 out_overflowed,
  output logic                 out_any_digits,
  output logic [15:0]          out_end_offset
);
  import tup_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign out_free = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load.valid) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load.valid) begin
      res_r <= load.res;
    end
  end

  assign out_valid      = valid_r;
  assign out_value      = res_r.value;
  assign out_overflowed = res_r.overflowed;
  assign out_any_digits = res_r.any_digits;
  assign out_end_offset = res_r.end_offset;

endmodule

// ===== rtl/text_to_unsigned_parser.sv =====
`timescale 1ns / 1ps
// Channel  | Direction | Handshake          | Payload
// in_      | input     | in_valid/in_stall  | ch[7:0], first
// out_     | output    | out_valid/out_stall| value[31:0], overflowed, any_digits, end_offset[15:0]
// cfg_     | input     | cfg_valid/cfg_ready| number_base[5:0]
//
// One character per cycle while the output does not stall; each result is registered.
// The character register feeds one multiply-add/compare pass into the result register.
// Reset (synchronous, rst_n low) restores base 10 and the whitespace-skipping state.
// A stalled result holds; the input register still takes a character while it is empty.

module text_to_unsigned_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_ch,
  input  logic        in_first,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_value,
  output logic        out_overflowed,
  output logic        out_any_digits,
  output logic [15:0] out_end_offset,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_number_base
);
  import tup_pkg::*;

  item_req_t   cur;
  result_req_t load;
  logic        out_free;

  assign cfg_ready = 1'b1;

  tup_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ch    (in_ch),
    .in_first (in_first),
    .in_stall (in_stall),
    .take_ok  (out_free),
    .cur      (cur)
  );

  tup_parse u_parse (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr          (cfg_valid && cfg_ready),
    .cfg_number_base (cfg_number_base),
    .cur             (cur),
    .out_free        (out_free),
    .load            (load)
  );

  tup_out_stage u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (load),
    .out_free       (out_free),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_value      (out_value),
    .out_overflowed (out_overflowed),
    .out_any_digits (out_any_digits),
    .out_end_offset (out_end_offset)
  );

endmodule

// ===== rtl/tup_checker.sv =====
`timescale 1ns / 1ps

module tup_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_value,
  input logic        out_overflowed,
  input logic        out_any_digits,
  input logic [15:0] out_end_offset
);

  // a stalled request keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value) &&
      $stable(out_end_offset) && $stable(out_overflowed) && $stable(out_any_digits))
    else $error("result changed while stalled");

  // saturation is all ones and only happens once digits were taken
  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflowed |-> out_value == 32'hFFFF_FFFF && out_any_digits)
    else $error("overflow result not saturated");

  a_no_digits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_any_digits |-> out_value == 32'd0 && out_end_offset == 16'd0)
    else $error("result without digits is not zero");

  // a rising result needs an accepted input request before it
  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without a preceding input");

endmodule

bind text_to_unsigned_parser tup_checker u_tup_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_value      (out_value),
  .out_overflowed (out_overflowed),
  .out_any_digits (out_any_digits),
  .out_end_offset (out_end_offset)
);
